/* sv/gpsle_pkg.sv */
// Shared types, constants and field-extraction functions for the LNAV
// ephemeris assembler. No dependencies; used by every module of the block.
`default_nettype none
package gpsle_pkg;

  localparam int NUM_SATS_DEF  = 32;
  localparam int SAT_W         = 5;
  localparam int POS_W         = 4;
  localparam int WORD_W        = 30;
  localparam int FID_W         = 6;
  localparam int VAL_W         = 33;
  localparam int WORDS_PER_SF  = 10;
  localparam int STORED_SF     = 3;
  localparam int LAST_SF       = 5;
  localparam int NUM_FIELDS    = 36;
  localparam int SF_CNT_W      = 3;
  localparam logic [WORD_W-1:0] FLIP_MASK = 30'h3fffffc0;
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(WORDS_PER_SF - 1);
  localparam logic [FID_W-1:0]  LAST_FID  = FID_W'(NUM_FIELDS - 1);
  localparam logic [SF_CNT_W-1:0] EMIT_SF = SF_CNT_W'(LAST_SF - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_RD0, ST_RD1, ST_IDCHK,
    ST_CPRD, ST_CPWR, ST_EA, ST_EB, ST_EC
  } state_t;

  typedef struct packed {
    logic wr_collect;
    logic upd_nwc;
    logic rd_collect;
    logic save_d30;
    logic latch_id;
    logic clr_idx;
    logic inc_idx;
    logic cp_write;
    logic rd_store;
    logic sel_b;
    logic latch_a;
    logic load_out;
    logic clr_fld;
    logic inc_fld;
  } cmd_t;

  typedef struct packed {
    logic word_ok;
    logic word_last;
    logic id_ok;
    logic exp_store;
    logic exp_emit;
    logic idx_last;
    logic fld_last;
    logic out_free;
  } status_t;

  // Subframe (0..2) that holds a field.
  function automatic logic [1:0] fld_sf(input logic [FID_W-1:0] k);
    logic [1:0] r;
    if (k < FID_W'(12)) r = 2'd0;
    else if (k < FID_W'(24)) r = 2'd1;
    else r = 2'd2;
    return r;
  endfunction

  // Word holding the field, or its high part for split fields.
  function automatic logic [POS_W-1:0] fld_wa(input logic [FID_W-1:0] k);
    logic [POS_W-1:0] r;
    case (k) inside
      6'd0, 6'd1, 6'd2, 6'd12, 6'd13, 6'd14, 6'd24, 6'd25, 6'd26: r = 4'd1;
      6'd3, 6'd4, 6'd5, 6'd6, 6'd15, 6'd16, 6'd27, 6'd28:          r = 4'd2;
      6'd17, 6'd18:                                                r = 4'd3;
      6'd29, 6'd30:                                                r = 4'd4;
      6'd19, 6'd20:                                                r = 4'd5;
      6'd7, 6'd31, 6'd32:                                          r = 4'd6;
      6'd8, 6'd21, 6'd22:                                          r = 4'd7;
      6'd10, 6'd11, 6'd33:                                         r = 4'd8;
      default:                                                     r = 4'd9;
    endcase
    return r;
  endfunction

  // Word holding the low part of a split field; same as fld_wa otherwise.
  function automatic logic [POS_W-1:0] fld_wb(input logic [FID_W-1:0] k);
    logic [POS_W-1:0] r;
    case (k) inside
      6'd6, 6'd32:  r = 4'd7;
      6'd18:        r = 4'd4;
      6'd20:        r = 4'd6;
      6'd22:        r = 4'd8;
      6'd28:        r = 4'd3;
      6'd30:        r = 4'd5;
      default:      r = fld_wa(k);
    endcase
    return r;
  endfunction

  // Raw field value from the word(s) that hold it.
  function automatic logic signed [VAL_W-1:0] fld_value(input logic [FID_W-1:0] k,
                                                       input logic [WORD_W-1:0] a,
                                                       input logic [WORD_W-1:0] b);
    logic signed [VAL_W-1:0] r;
    case (k) inside
      6'd0, 6'd12, 6'd24:  r = VAL_W'(a[29:13]);
      6'd1, 6'd13, 6'd25:  r = VAL_W'(a[12]);
      6'd2, 6'd14, 6'd26:  r = VAL_W'(a[11]);
      6'd3:                r = VAL_W'(a[29:20]);
      6'd4:                r = VAL_W'(a[17:14]);
      6'd5:                r = VAL_W'(a[13:8]);
      6'd6:                r = VAL_W'({a[7:6], b[29:22]});
      6'd7:                r = VAL_W'($signed(a[13:6]));
      6'd8:                r = VAL_W'({a[21:6], 4'b0000});
      6'd9:                r = VAL_W'($signed(a[29:8]));
      6'd10, 6'd16:        r = VAL_W'($signed(a[21:6]));
      6'd11:               r = VAL_W'($signed(a[29:22]));
      6'd15, 6'd34:        r = VAL_W'(a[29:22]);
      6'd17, 6'd19, 6'd21, 6'd27, 6'd29, 6'd31:
                           r = VAL_W'($signed(a[29:14]));
      6'd18, 6'd28, 6'd30, 6'd32:
                           r = VAL_W'($signed({a[13:6], b[29:6]}));
      6'd20, 6'd22:        r = VAL_W'({a[13:6], b[29:6]});
      6'd23:               r = VAL_W'({a[29:14], 4'b0000});
      6'd33:               r = VAL_W'($signed(a[29:6]));
      6'd35:               r = VAL_W'($signed(a[21:8]));
      default:             r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/gpsle_ctrl.sv */
// Sequencing state machine of the LNAV ephemeris assembler.
// Depends on gpsle_pkg for the state type and the command/status structs.
`default_nettype none
module gpsle_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gpsle_pkg::status_t sts,
  output gpsle_pkg::cmd_t        cmd
);
  import gpsle_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (sts.word_ok && sts.word_last) ? ST_RD0 : ST_IDLE;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_IDCHK;
      ST_IDCHK: begin
        if (!sts.id_ok)         state_nxt = ST_IDLE;
        else if (sts.exp_store) state_nxt = ST_CPRD;
        else if (sts.exp_emit)  state_nxt = ST_EA;
        else                    state_nxt = ST_IDLE;
      end
      ST_CPRD:  state_nxt = ST_CPWR;
      ST_CPWR:  state_nxt = sts.idx_last ? ST_IDLE : ST_CPRD;
      ST_EA:    state_nxt = ST_EB;
      ST_EB:    state_nxt = ST_EC;
      ST_EC: begin
        if (sts.out_free) state_nxt = sts.fld_last ? ST_IDLE : ST_EA;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:  ;
      ST_CHECK: begin
        cmd.wr_collect = sts.word_ok;
        cmd.upd_nwc    = sts.word_ok;
        cmd.clr_idx    = 1'b1;
      end
      ST_RD0: begin
        cmd.rd_collect = 1'b1;
        cmd.inc_idx    = 1'b1;
      end
      ST_RD1: begin
        cmd.rd_collect = 1'b1;
        cmd.save_d30   = 1'b1;
      end
      ST_IDCHK: begin
        cmd.latch_id = 1'b1;
        cmd.clr_idx  = 1'b1;
        cmd.clr_fld  = 1'b1;
      end
      ST_CPRD:  cmd.rd_collect = 1'b1;
      ST_CPWR: begin
        cmd.cp_write = 1'b1;
        cmd.save_d30 = 1'b1;
        cmd.inc_idx  = 1'b1;
      end
      ST_EA:    cmd.rd_store = 1'b1;
      ST_EB: begin
        cmd.latch_a  = 1'b1;
        cmd.rd_store = 1'b1;
        cmd.sel_b    = 1'b1;
      end
      ST_EC: begin
        cmd.load_out = sts.out_free;
        cmd.inc_fld  = sts.out_free;
      end
      default:  ;
    endcase
  end

endmodule
`default_nettype wire

/* sv/gpsle_dpath.sv */
// Datapath of the LNAV ephemeris assembler: per-satellite counters, the word
// collection and subframe memories, and the result register. Uses gpsle_pkg.
`default_nettype none
module gpsle_dpath #(
  parameter int NUM_SATS = gpsle_pkg::NUM_SATS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_stall,
  input  wire logic [gpsle_pkg::SAT_W-1:0]        in_satellite,
  input  wire logic [gpsle_pkg::POS_W-1:0]        in_word_position,
  input  wire logic [gpsle_pkg::WORD_W-1:0]       in_nav_word,
  input  wire gpsle_pkg::cmd_t                    cmd,
  output gpsle_pkg::status_t                      sts,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [gpsle_pkg::SAT_W-1:0]             out_sat_out,
  output logic [gpsle_pkg::FID_W-1:0]             out_field_id,
  output logic signed [gpsle_pkg::VAL_W-1:0]      out_field_value,
  output logic                                    out_last_field
);
  import gpsle_pkg::*;

  localparam int SAT_IW = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;
  localparam int C_DEPTH = NUM_SATS * WORDS_PER_SF;
  localparam int S_DEPTH = NUM_SATS * STORED_SF * WORDS_PER_SF;
  localparam int C_AW = $clog2(C_DEPTH);
  localparam int S_AW = $clog2(S_DEPTH);

  logic [SAT_W-1:0]    sat_r;
  logic [POS_W-1:0]    pos_r;
  logic [WORD_W-1:0]   word_r;
  logic [POS_W-1:0]    nwc_r [NUM_SATS];
  logic [SF_CNT_W-1:0] nsc_r [NUM_SATS];
  logic [SF_CNT_W-1:0] exp_r;
  logic [POS_W-1:0]    idx_r;
  logic [FID_W-1:0]    fld_r;
  logic                d30_r;
  logic [WORD_W-1:0]   a_r;
  logic [WORD_W-1:0]   c_mem [C_DEPTH];
  logic [WORD_W-1:0]   s_mem [S_DEPTH];
  logic [WORD_W-1:0]   c_rd_r;
  logic [WORD_W-1:0]   s_rd_r;
  logic                out_valid_r;
  logic [SAT_W-1:0]    out_sat_r;
  logic [FID_W-1:0]    out_fid_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic                out_last_r;

  logic [SAT_IW-1:0]   sat_i;
  logic                sat_in_range;
  logic [SF_CNT_W-1:0] exp_cur;
  logic [WORD_W-1:0]   corr_word;
  logic [C_AW-1:0]     c_addr;
  logic [S_AW-1:0]     s_addr;
  logic [1:0]          s_sf;
  logic [POS_W-1:0]    s_word;

  assign sat_i        = SAT_IW'(sat_r);
  assign sat_in_range = (int'(sat_r) < NUM_SATS);
  assign exp_cur      = nsc_r[sat_i];
  // Data bits flip when the previous word's D30 is set.
  assign corr_word    = c_rd_r ^ (d30_r ? FLIP_MASK : '0);

  assign sts.word_ok   = sat_in_range && (pos_r == nwc_r[sat_i]);
  assign sts.word_last = (pos_r == LAST_POS);
  assign sts.id_ok     = (corr_word[10:8] == exp_cur + SF_CNT_W'(1));
  assign sts.exp_store = (exp_cur < SF_CNT_W'(STORED_SF));
  assign sts.exp_emit  = (exp_cur == EMIT_SF);
  assign sts.idx_last  = (idx_r == LAST_POS);
  assign sts.fld_last  = (fld_r == LAST_FID);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign c_addr = C_AW'(sat_r) * C_AW'(WORDS_PER_SF)
                + C_AW'(cmd.wr_collect ? pos_r : idx_r);

  assign s_sf   = cmd.cp_write ? exp_r[1:0] : fld_sf(fld_r);
  assign s_word = cmd.cp_write ? idx_r : (cmd.sel_b ? fld_wb(fld_r) : fld_wa(fld_r));
  assign s_addr = S_AW'(sat_r) * S_AW'(STORED_SF * WORDS_PER_SF)
                + S_AW'(s_sf) * S_AW'(WORDS_PER_SF) + S_AW'(s_word);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      sat_r  <= in_satellite;
      pos_r  <= in_word_position;
      word_r <= in_nav_word;
    end
    if (cmd.wr_collect) c_mem[c_addr] <= word_r;
    if (cmd.rd_collect) c_rd_r <= c_mem[c_addr];
    if (cmd.cp_write)   s_mem[s_addr] <= corr_word;
    if (cmd.rd_store)   s_rd_r <= s_mem[s_addr];
    if (cmd.latch_a)    a_r <= s_rd_r;
    if (cmd.latch_id)   exp_r <= exp_cur;
    if (cmd.latch_id)      d30_r <= 1'b0;
    else if (cmd.save_d30) d30_r <= c_rd_r[0];
    if (cmd.clr_idx)      idx_r <= '0;
    else if (cmd.inc_idx) idx_r <= idx_r + POS_W'(1);
    if (cmd.clr_fld)      fld_r <= '0;
    else if (cmd.inc_fld) fld_r <= fld_r + FID_W'(1);
    if (cmd.load_out) begin
      out_sat_r  <= sat_r;
      out_fid_r  <= fld_r;
      out_val_r  <= fld_value(fld_r, a_r, s_rd_r);
      out_last_r <= (fld_r == LAST_FID);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SATS; i++) begin
        nwc_r[i] <= '0;
        nsc_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd_nwc) nwc_r[sat_i] <= sts.word_last ? '0 : pos_r + POS_W'(1);
      if (cmd.latch_id && sts.id_ok)
        nsc_r[sat_i] <= sts.exp_emit ? '0 : exp_cur + SF_CNT_W'(1);
      if (cmd.load_out)     out_valid_r <= 1'b1;
      else if (!out_stall)  out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sat_out     = out_sat_r;
  assign out_field_id    = out_fid_r;
  assign out_field_value = out_val_r;
  assign out_last_field  = out_last_r;

endmodule
`default_nettype wire

/* sv/gps_lnav_ephemeris_assembler_core.sv */
// Top level of the LNAV ephemeris assembler: controller plus datapath.
// Depends on gpsle_pkg, gpsle_ctrl and gpsle_dpath.
`default_nettype none
// The block takes 30-bit LNAV words tagged with a satellite channel and a
// word position, keeps per satellite only the word it expects next, and after
// ten words corrects data polarity from the previous word's D30 and checks
// the subframe ID in the HOW. Subframes must come in order 1 to 5; one out of
// order is dropped. Subframes 1 to 3 are stored, and when subframe 5 passes
// the block sends 36 beats, one per raw ephemeris field (ids 0 to 35, last
// field flagged), with toc and toe already multiplied by 16. For subframes 1
// to 3 the tenth word starts a ten-word copy through the single-ported
// subframe memory, a read of the collection memory and a write for each word.
// Subframe 5 starts the emission, with two reads per field from that memory;
// a stall from the receiver holds the emission. The input is stalled while a
// word is being processed; finished beats wait in an output register. The
// memories need no clearing after reset.
module gps_lnav_ephemeris_assembler_core #(
  parameter int NUM_SATS = gpsle_pkg::NUM_SATS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [gpsle_pkg::SAT_W-1:0]   in_satellite,
  input  wire logic [gpsle_pkg::POS_W-1:0]   in_word_position,
  input  wire logic [gpsle_pkg::WORD_W-1:0]  in_nav_word,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [gpsle_pkg::SAT_W-1:0]        out_sat_out,
  output logic [gpsle_pkg::FID_W-1:0]        out_field_id,
  output logic signed [gpsle_pkg::VAL_W-1:0] out_field_value,
  output logic                               out_last_field
);
  import gpsle_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // The controller sequences word checks, the polarity copy and emission.
  gpsle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds all storage and builds each field value.
  gpsle_dpath #(
    .NUM_SATS (NUM_SATS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_satellite     (in_satellite),
    .in_word_position (in_word_position),
    .in_nav_word      (in_nav_word),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sat_out      (out_sat_out),
    .out_field_id     (out_field_id),
    .out_field_value  (out_field_value),
    .out_last_field   (out_last_field)
  );

endmodule
`default_nettype wire
